// File: src/xbf_pkg.sv
// ----------------------------------------------------------------------------
// xbf_pkg
// Shared constants and types for the XMODEM block framer: header bytes,
// mode codes and the per-item result bundle passed to the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package xbf_pkg;

   // framing bytes
   localparam logic [7:0] HDR_SOH  = 8'h01;
   localparam logic [7:0] HDR_STX  = 8'h02;
   localparam logic [7:0] EOT_BYTE = 8'h04;
   localparam logic [7:0] PAD_BYTE = 8'h1A;

   // CRC-16/XMODEM polynomial
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // mode register codes
   localparam logic [1:0] MODE_SUM_128 = 2'd0;
   localparam logic [1:0] MODE_CRC_128 = 2'd1;
   localparam logic [1:0] MODE_CRC_1K  = 2'd2;

   // last payload position of a block
   localparam logic [9:0] LAST_POS_128 = 10'd127;
   localparam logic [9:0] LAST_POS_1K  = 10'd1023;

   // input command codes
   localparam logic CMD_PAYLOAD = 1'b0;
   localparam logic CMD_EOT     = 1'b1;

   // most result bytes one item can cause
   localparam int MAX_RESULTS = 4;
   localparam int IDX_W       = $clog2(MAX_RESULTS);

   // results of one item: bytes in send order from index 0,
   // index of the last byte, and end-of-frame flag for that last byte
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [IDX_W-1:0]            last_idx;
      logic                        frame_end;
   } result_type;

endpackage

`default_nettype wire

// File: src/xbf_framer.sv
// ----------------------------------------------------------------------------
// xbf_framer
// Block state (position, CRC, checksum, mode) and the single-pass logic that
// turns one accepted item into the list of framed bytes it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module xbf_framer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   input  wire logic [1:0]          csr_wdata,
   input  wire logic                take,
   input  wire logic                command,
   input  wire logic [7:0]          data_byte,
   input  wire logic                byte_present,
   input  wire logic [7:0]          block_number,
   output xbf_pkg::result_type      result
);
   import xbf_pkg::*;

   // one byte of CRC-16/XMODEM, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   logic [1:0]  mode_ff;
   logic [9:0]  position_ff, position_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  sum_ff, sum_in;

   logic        onek;
   logic        use_sum;
   logic [9:0]  last_pos;
   logic        first_pos;
   logic        last_hit;
   logic [7:0]  pay_byte;
   logic [15:0] crc_base;
   logic [7:0]  sum_base;
   logic [15:0] crc_new;
   logic [7:0]  sum_new;

   // mode register; the user must write it only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CRC_128;
      end else if (csr_valid) begin
         mode_ff <= csr_wdata;
      end
   end

   // mode decode: bit 1 picks 1K blocks, only mode 0 uses the checksum
   assign onek     = mode_ff[1];
   assign use_sum  = (mode_ff == MODE_SUM_128);
   assign last_pos = onek ? LAST_POS_1K : LAST_POS_128;

   // payload byte and running checks; a new block starts from zero
   assign first_pos = (position_ff == 10'd0);
   assign last_hit  = (position_ff >= last_pos);
   assign pay_byte  = byte_present ? data_byte : PAD_BYTE;
   assign crc_base  = first_pos ? 16'h0000 : crc_ff;
   assign sum_base  = first_pos ? 8'h00 : sum_ff;
   assign crc_new   = crc_byte(crc_base, pay_byte);
   assign sum_new   = sum_base + pay_byte;

   // build the result list and the next block state
   always_comb begin
      result      = '0;
      position_in = position_ff;
      crc_in      = crc_ff;
      sum_in      = sum_ff;
      if (command == CMD_EOT) begin
         result.bytes[0]  = EOT_BYTE;
         result.last_idx  = IDX_W'(0);
         result.frame_end = 1'b1;
         position_in      = 10'd0;
         crc_in           = 16'h0000;
         sum_in           = 8'h00;
      end else begin
         crc_in = crc_new;
         sum_in = sum_new;
         if (first_pos) begin
            result.bytes[0] = onek ? HDR_STX : HDR_SOH;
            result.bytes[1] = block_number;
            result.bytes[2] = ~block_number;
            result.bytes[3] = pay_byte;
            result.last_idx = IDX_W'(3);
         end else begin
            result.bytes[0] = pay_byte;
            result.last_idx = IDX_W'(0);
            if (last_hit) begin
               result.frame_end = 1'b1;
               if (use_sum) begin
                  result.bytes[1] = sum_new;
                  result.last_idx = IDX_W'(1);
               end else begin
                  result.bytes[1] = crc_new[15:8];
                  result.bytes[2] = crc_new[7:0];
                  result.last_idx = IDX_W'(2);
               end
            end
         end
         // position zero is never the last one (blocks are 128 or more)
         position_in = last_hit ? 10'd0 : 10'(position_ff + 10'd1);
      end
   end

   // block state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 10'd0;
         crc_ff      <= 16'h0000;
         sum_ff      <= 8'h00;
      end else if (take) begin
         position_ff <= position_in;
         crc_ff      <= crc_in;
         sum_ff      <= sum_in;
      end
   end

   // header item always carries four bytes
   a_header_len: assert property (@(posedge clock) disable iff (reset)
      (take && command == CMD_PAYLOAD && first_pos) |-> (result.last_idx == IDX_W'(3)))
      else $error("header item without four bytes");

   // EOT clears the block state
   a_eot_clear: assert property (@(posedge clock) disable iff (reset)
      (take && command == CMD_EOT) |=> (position_ff == 10'd0 && crc_ff == 16'h0000
                                         && sum_ff == 8'h00))
      else $error("block state not cleared after EOT");

   // a check is emitted exactly when position wraps to zero on payload
   a_wrap_check: assert property (@(posedge clock) disable iff (reset)
      (take && command == CMD_PAYLOAD) |-> (result.frame_end == (position_in == 10'd0)))
      else $error("frame end disagrees with position wrap");

endmodule

`default_nettype wire

// File: src/xbf_out_buffer.sv
// ----------------------------------------------------------------------------
// xbf_out_buffer
// Result register: holds the bytes of one item and shifts them out one per
// handshake. Reloads in the same cycle its final byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module xbf_out_buffer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  xbf_pkg::result_type      load_data,
   output logic                     can_load,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast,
   output logic                     rsp_tuser
);
   import xbf_pkg::*;

   logic                        valid_ff, valid_in;
   logic [MAX_RESULTS-1:0][7:0] bytes_ff, bytes_in;
   logic [IDX_W-1:0]            remain_ff, remain_in;
   logic                        fend_ff, fend_in;
   logic                        pop;
   logic                        final_byte;

   assign pop        = valid_ff && rsp_tready;
   assign final_byte = (remain_ff == IDX_W'(0));
   assign can_load   = !valid_ff || (pop && final_byte);

   // next buffer contents: load, shift by one byte, or hold
   always_comb begin
      valid_in  = valid_ff;
      bytes_in  = bytes_ff;
      remain_in = remain_ff;
      fend_in   = fend_ff;
      if (load) begin
         valid_in  = 1'b1;
         bytes_in  = load_data.bytes;
         remain_in = load_data.last_idx;
         fend_in   = load_data.frame_end;
      end else if (pop) begin
         valid_in  = !final_byte;
         bytes_in  = {8'h00, bytes_ff[MAX_RESULTS-1:1]};
         remain_in = IDX_W'(remain_ff - IDX_W'(1));
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      bytes_ff  <= bytes_in;
      remain_ff <= remain_in;
      fend_ff   <= fend_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = bytes_ff[0];
   assign rsp_tlast  = final_byte;
   assign rsp_tuser  = final_byte && fend_ff;

   // never overwrite bytes still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!valid_ff || (pop && final_byte)))
      else $error("result buffer overwritten");

   // a taken byte that is not the final one leaves more to send
   a_more_left: assert property (@(posedge clock) disable iff (reset)
      (pop && !final_byte && !load) |=> (valid_ff && remain_ff == $past(remain_ff) - IDX_W'(1)))
      else $error("result bytes lost");

   // idle buffer after its final byte unless reloaded
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && final_byte && !load) |=> !valid_ff)
      else $error("result repeated after final byte");

endmodule

`default_nettype wire

// File: src/xmodem_block_framer_unit.sv
// Latency: first result byte is offered the cycle after its item is accepted.
// Throughput: an item occupies the result register until each byte it causes
// (1 to 4) is taken; the next item is taken in the cycle the last byte leaves,
// so the output register, one byte per cycle while rsp_tready holds, sets the rate.
// Reset: synchronous; clears block position and checks, sets mode to 1.
// ----------------------------------------------------------------------------
// xmodem_block_framer_unit
// XMODEM sender framer: header, block number, padded payload and
// checksum or CRC-16 trailer, plus EOT, emitted as a byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module xmodem_block_framer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration: mode
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_wdata,   // [1:0] mode
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [7:0] data_byte, [8] byte_present,
                                         // [16:9] block_number, [23:17] zero
   input  wire logic        req_tuser,   // [0] command
   // result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast,   // run_last
   output logic             rsp_tuser    // [0] frame_end
);
   import xbf_pkg::*;

   logic       take;
   logic       can_load;
   result_type result;

   assign csr_ready  = 1'b1;
   assign req_tready = can_load;
   assign take       = req_tvalid && can_load;

   // item to result list
   xbf_framer u_framer (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_wdata    (csr_wdata),
      .take         (take),
      .command      (req_tuser),
      .data_byte    (req_tdata[7:0]),
      .byte_present (req_tdata[8]),
      .block_number (req_tdata[16:9]),
      .result       (result)
   );

   // result register and byte serializer
   xbf_out_buffer u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .load_data  (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: XMODEM block framer testbench
// Feeds payload positions and end commands through the req stream and
// checks every framed byte on the rsp stream against a local model of the
// framer: header, block number and complement, padded payload, then the
// checksum or CRC-16 trailer. Runs all four mode codes, with mode changes
// in the middle of a block, random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import xbf_pkg::*;

   // mode 3 has bit 1 set and is not the checksum code: CRC with 1K blocks
   localparam logic [1:0] MODE_CRC_1K_ALT = 2'd3;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
      logic       present;
      logic [7:0] blk_num;
   } frame_req_t;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } frame_byte_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   frame_req_t  pending_q[$];
   frame_byte_t framed_bytes_q[$];
   frame_req_t  cur_req;
   frame_byte_t want;
   bit          offering = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          items_sent = 0;
   int          bytes_seen = 0;
   int          frames_seen = 0;
   int          errors = 0;
   int          cycle_count = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          stall_style = 0;
   int          style_left = 0;

   // framer model state
   logic [1:0]  tx_mode = MODE_CRC_128;
   logic [9:0]  blk_pos = '0;
   logic [15:0] blk_crc = '0;
   logic [7:0]  blk_sum = '0;

   xmodem_block_framer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // CRC-16/XMODEM, one byte, MSB first
   function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
         r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      return r;
   endfunction

   function automatic frame_byte_t mk_byte(logic [7:0] b, logic fe);
      frame_byte_t f;
      f.out_byte  = b;
      f.run_last  = 1'b0;
      f.frame_end = fe;
      return f;
   endfunction

   // work out the bytes one accepted item causes and queue them
   function automatic void frame_item(frame_req_t r);
      frame_byte_t outs[$];
      logic        onek;
      logic        use_sum;
      logic [9:0]  last_pos;
      logic [7:0]  pay;
      onek     = tx_mode[1];
      use_sum  = (tx_mode == MODE_SUM_128);
      last_pos = onek ? LAST_POS_1K : LAST_POS_128;
      if (r.cmd == CMD_EOT) begin
         // end command drops any partial block
         outs.push_back(mk_byte(EOT_BYTE, 1'b1));
         blk_pos = '0;
         blk_crc = '0;
         blk_sum = '0;
      end else begin
         if (blk_pos == '0) begin
            blk_crc = '0;
            blk_sum = '0;
            outs.push_back(mk_byte(onek ? HDR_STX : HDR_SOH, 1'b0));
            outs.push_back(mk_byte(r.blk_num, 1'b0));
            outs.push_back(mk_byte(~r.blk_num, 1'b0));
         end
         pay     = r.present ? r.data : PAD_BYTE;
         blk_crc = crc16_step(blk_crc, pay);
         blk_sum = blk_sum + pay;
         outs.push_back(mk_byte(pay, 1'b0));
         // a position past the block end (after a mode change) closes it too
         if (blk_pos >= last_pos) begin
            if (use_sum) begin
               outs.push_back(mk_byte(blk_sum, 1'b1));
            end else begin
               outs.push_back(mk_byte(blk_crc[15:8], 1'b0));
               outs.push_back(mk_byte(blk_crc[7:0], 1'b1));
            end
            blk_pos = '0;
         end else begin
            blk_pos = blk_pos + 10'd1;
         end
      end
      outs[outs.size()-1].run_last = 1'b1;
      foreach (outs[i]) framed_bytes_q.push_back(outs[i]);
   endfunction

   // sender: bursts of items with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            frame_item(cur_req);
            items_sent++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() != 0) begin
               cur_req  = pending_q.pop_front();
               offering = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 31);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_tvalid <= offering;
         if (offering) begin
            req_tdata <= {7'b0, cur_req.blk_num, cur_req.present, cur_req.data};
            req_tuser <= cur_req.cmd;
         end
      end
   end

   // receiver: changing stall patterns, one long hold-off, byte checks
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            bytes_seen++;
            if (rsp_tuser) frames_seen++;
            if (framed_bytes_q.size() == 0) begin
               errors++;
               $error("result item with none expected: out_byte %h", rsp_tdata);
            end else begin
               want = framed_bytes_q.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  errors++;
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_tdata);
               end
               if (rsp_tlast !== want.run_last) begin
                  errors++;
                  $error("run_last: expected %b, got %b", want.run_last, rsp_tlast);
               end
               if (rsp_tuser !== want.frame_end) begin
                  errors++;
                  $error("frame_end: expected %b, got %b", want.frame_end, rsp_tuser);
               end
            end
         end
         if (!hold_done && items_sent >= 60) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 120);
         end else begin
            style_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= cycle_count[0];
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes outstanding",
                  cycle_count, framed_bytes_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_req(logic cmd, logic [7:0] d, logic p, logic [7:0] bn);
      frame_req_t r;
      r.cmd     = cmd;
      r.data    = d;
      r.present = p;
      r.blk_num = bn;
      pending_q.push_back(r);
   endtask

   // n payload positions; pads from position pad_from on, a few random pads
   task automatic queue_block(int n, logic [7:0] bn, int pad_from);
      for (int i = 0; i < n; i++)
         queue_req(CMD_PAYLOAD, 8'($urandom), (i < pad_from) && ($urandom_range(0, 15) != 0),
                   (i == 0) ? bn : 8'($urandom));
   endtask

   task automatic queue_eot();
      queue_req(CMD_EOT, 8'($urandom), 1'($urandom), 8'($urandom));
   endtask

   // sender pause: wait until every queued byte has come back
   task automatic wait_drained();
      while (pending_q.size() != 0 || offering || framed_bytes_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic [1:0] m);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tx_mode = m;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, reset mode (CRC 128)
      queue_req(CMD_EOT, 8'h00, 1'b0, 8'h00);      // end before any block
      queue_req(CMD_PAYLOAD, 8'h00, 1'b1, 8'h00);  // header with block 0
      queue_req(CMD_PAYLOAD, 8'hFF, 1'b1, 8'hFF);
      queue_req(CMD_PAYLOAD, 8'h55, 1'b0, 8'h12);  // pad
      queue_req(CMD_PAYLOAD, 8'hA5, 1'b1, 8'h00);
      queue_req(CMD_PAYLOAD, 8'h5A, 1'b1, 8'h00);
      queue_req(CMD_EOT, 8'hFF, 1'b1, 8'hFF);      // abandon partial block
      queue_req(CMD_PAYLOAD, 8'h80, 1'b1, 8'hFF);  // new header, block 255
      queue_req(CMD_PAYLOAD, 8'hFF, 1'b0, 8'hAA);
      queue_req(CMD_PAYLOAD, 8'h01, 1'b1, 8'h55);
      queue_eot();
      wait_drained();

      // checksum mode: full block, then a partial one cut by an end
      write_mode(MODE_SUM_128);
      queue_block(128, 8'h01, 100);
      queue_block(10, 8'h02, 5);
      queue_eot();
      wait_drained();

      // mode 3 block switched to CRC 128 past position 127 closes at once
      write_mode(MODE_CRC_1K_ALT);
      queue_block(130, 8'h07, 130);
      wait_drained();
      write_mode(MODE_CRC_128);
      queue_req(CMD_PAYLOAD, 8'($urandom), 1'b1, 8'($urandom));
      queue_block(5, 8'h08, 2);
      queue_eot();
      wait_drained();

      // CRC 128 block moved to 1K mode part way, then ended
      queue_block(10, 8'h09, 10);
      wait_drained();
      write_mode(MODE_CRC_1K);
      queue_block(5, 8'h00, 3);
      queue_eot();
      wait_drained();

      $display("framed %0d items into %0d bytes, %0d frame ends",
               items_sent, bytes_seen, frames_seen);
      $display("modes 0..3 with mid-block mode changes, pads, ends and stalls");
      if (errors == 0 && framed_bytes_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
